// ----- src/bba_pkg.sv -----
// Shared constants, types and codes for the block bitmap allocator.
`timescale 1ns / 1ps

package bba_pkg;

    localparam int MAX_BLOCKS   = 4096;
    localparam int WORD_BITS    = 32;
    localparam int MAP_WORDS    = MAX_BLOCKS / WORD_BITS;
    localparam int BLK_W        = $clog2(MAX_BLOCKS);
    localparam int BIT_W        = $clog2(WORD_BITS);
    localparam int ADDR_W       = $clog2(MAP_WORDS);
    localparam int REG_W        = 13;
    localparam int STATUS_W     = 2;
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_TDATA_W  = 16;
    localparam int OUT_PAD_W    = OUT_TDATA_W - BLK_W - STATUS_W;

    localparam logic [REG_W-1:0] TOTAL_RESET = 13'd4096;
    localparam logic [REG_W-1:0] FIRST_RESET = 13'd0;

    localparam logic REG_TOTAL_BLOCKS = 1'b0;
    localparam logic REG_FIRST_DATA   = 1'b1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_NO_FREE      = 2'd1,
        ST_ALREADY_FREE = 2'd2,
        ST_RANGE        = 2'd3
    } status_t;

    typedef struct packed {
        logic capture;
        logic rd_first;
        logic rd_blk;
        logic scan_step;
        logic alloc_hit;
        logic set_no_free;
        logic set_range;
        logic free_eval;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic op_free;
        logic empty;
        logic range_err;
        logic found;
        logic at_last;
        logic out_free;
    } sts_t;

endpackage

// ----- src/bba_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/bba_datapath.sv -----
// Allocator datapath: config registers, bitmap RAM, word scan and result registers.
`timescale 1ns / 1ps

module bba_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [bba_pkg::REG_W-1:0]      cfg_data,
    input  logic                           s_tuser,
    input  logic [bba_pkg::IN_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bba_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  bba_pkg::cmd_t                  cmd,
    output bba_pkg::sts_t                  sts
);

    logic [bba_pkg::REG_W-1:0]     total_reg;
    logic [bba_pkg::REG_W-1:0]     first_reg;
    logic                          op_reg;
    logic [bba_pkg::BLK_W-1:0]     blk_reg;
    logic [bba_pkg::ADDR_W-1:0]    ev_word_reg;
    logic [bba_pkg::ADDR_W-1:0]    nxt_word_reg;
    logic [bba_pkg::MAP_WORDS-1:0] row_valid_reg;
    logic                          rd_valid_reg;
    logic [bba_pkg::BLK_W-1:0]     res_block_reg;
    bba_pkg::status_t              res_status_reg;
    logic [bba_pkg::BLK_W-1:0]     out_block_reg;
    bba_pkg::status_t              out_status_reg;
    logic                          out_valid_reg;

    logic [bba_pkg::REG_W-1:0]     count;
    logic [bba_pkg::REG_W-1:0]     count_m1;
    logic [bba_pkg::ADDR_W-1:0]    first_word;
    logic [bba_pkg::ADDR_W-1:0]    last_word;
    logic [bba_pkg::ADDR_W-1:0]    blk_word;
    logic [bba_pkg::BIT_W-1:0]     blk_bit;
    logic [bba_pkg::ADDR_W-1:0]    raddr;
    logic                          rd_cmd;
    logic [bba_pkg::WORD_BITS-1:0] rdata;
    logic [bba_pkg::WORD_BITS-1:0] word_data;
    logic [bba_pkg::WORD_BITS-1:0] ones;
    logic [bba_pkg::WORD_BITS-1:0] lo_mask;
    logic [bba_pkg::WORD_BITS-1:0] hi_mask;
    logic [bba_pkg::WORD_BITS-1:0] avail;
    logic [bba_pkg::BIT_W-1:0]     hit_bit;
    logic                          blk_set;
    logic                          we;
    logic [bba_pkg::WORD_BITS-1:0] wdata;
    logic                          out_free;

    assign count      = (total_reg > bba_pkg::REG_W'(bba_pkg::MAX_BLOCKS))
                      ? bba_pkg::REG_W'(bba_pkg::MAX_BLOCKS) : total_reg;
    assign count_m1   = count - bba_pkg::REG_W'(1);
    assign first_word = first_reg[bba_pkg::BLK_W-1:bba_pkg::BIT_W];
    assign last_word  = count_m1[bba_pkg::BLK_W-1:bba_pkg::BIT_W];
    assign blk_word   = blk_reg[bba_pkg::BLK_W-1:bba_pkg::BIT_W];
    assign blk_bit    = blk_reg[bba_pkg::BIT_W-1:0];

    assign rd_cmd = cmd.rd_first | cmd.rd_blk | cmd.scan_step;
    assign raddr  = cmd.rd_first ? first_word
                  : cmd.rd_blk   ? blk_word
                  : nxt_word_reg;

    // rows never written since reset read as all free
    assign word_data = rd_valid_reg ? rdata : '0;

    assign ones    = '1;
    assign lo_mask = (ev_word_reg == first_word)
                   ? (ones << first_reg[bba_pkg::BIT_W-1:0]) : ones;
    assign hi_mask = (ev_word_reg == last_word)
                   ? (ones >> (bba_pkg::BIT_W'(bba_pkg::WORD_BITS - 1)
                               - count_m1[bba_pkg::BIT_W-1:0]))
                   : ones;
    assign avail   = ~word_data & lo_mask & hi_mask;

    always_comb
    begin
        hit_bit = '0;
        for (int i = bba_pkg::WORD_BITS - 1; i >= 0; i--)
        begin
            if (avail[i])
            begin
                hit_bit = bba_pkg::BIT_W'(i);
            end
        end
    end

    assign blk_set = word_data[blk_bit];

    assign we    = cmd.alloc_hit | (cmd.free_eval & blk_set);
    assign wdata = cmd.alloc_hit
                 ? (word_data | (bba_pkg::WORD_BITS'(1) << hit_bit))
                 : (word_data & ~(bba_pkg::WORD_BITS'(1) << blk_bit));

    bba_ram #(
        .WIDTH (bba_pkg::WORD_BITS),
        .DEPTH (bba_pkg::MAP_WORDS)
    ) u_map (
        .clk   (clk),
        .we    (we),
        .waddr (ev_word_reg),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign out_free = ~out_valid_reg | m_tready;

    assign sts.op_free   = op_reg;
    assign sts.empty     = (first_reg >= count);
    assign sts.range_err = ({1'b0, blk_reg} >= count) || ({1'b0, blk_reg} < first_reg);
    assign sts.found     = |avail;
    assign sts.at_last   = (ev_word_reg == last_word);
    assign sts.out_free  = out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= bba_pkg::TOTAL_RESET;
            first_reg     <= bba_pkg::FIRST_RESET;
            row_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    bba_pkg::REG_TOTAL_BLOCKS: total_reg <= cfg_data;
                    bba_pkg::REG_FIRST_DATA:   first_reg <= cfg_data;
                    default:                   ;
                endcase
            end
            if (we)
            begin
                row_valid_reg[ev_word_reg] <= 1'b1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_valid_reg <= row_valid_reg[raddr];
        if (cmd.capture)
        begin
            op_reg  <= s_tuser;
            blk_reg <= s_tdata[bba_pkg::BLK_W-1:0];
        end
        if (rd_cmd)
        begin
            ev_word_reg  <= raddr;
            nxt_word_reg <= raddr + bba_pkg::ADDR_W'(1);
        end
        if (cmd.alloc_hit)
        begin
            res_block_reg  <= {ev_word_reg, hit_bit};
            res_status_reg <= bba_pkg::ST_OK;
        end
        else if (cmd.set_no_free)
        begin
            res_block_reg  <= '0;
            res_status_reg <= bba_pkg::ST_NO_FREE;
        end
        else if (cmd.set_range)
        begin
            res_block_reg  <= '0;
            res_status_reg <= bba_pkg::ST_RANGE;
        end
        else if (cmd.free_eval)
        begin
            res_block_reg  <= '0;
            res_status_reg <= blk_set ? bba_pkg::ST_OK : bba_pkg::ST_ALREADY_FREE;
        end
        if (cmd.load_out)
        begin
            out_block_reg  <= res_block_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{bba_pkg::OUT_PAD_W{1'b0}}, out_status_reg, out_block_reg};

endmodule

// ----- src/bba_ctrl.sv -----
// Allocator controller: sequences capture, bitmap scan, free check and result hand-off.
`timescale 1ns / 1ps

module bba_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  bba_pkg::sts_t sts,
    output bba_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_FREE_EV,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.op_free)
                begin
                    if (sts.range_err)
                    begin
                        cmd.set_range = 1'b1;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        cmd.rd_blk = 1'b1;
                        state_next = S_FREE_EV;
                    end
                end
                else if (sts.empty)
                begin
                    cmd.set_no_free = 1'b1;
                    state_next      = S_DONE;
                end
                else
                begin
                    cmd.rd_first = 1'b1;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.found)
                begin
                    cmd.alloc_hit = 1'b1;
                    state_next    = S_DONE;
                end
                else if (sts.at_last)
                begin
                    cmd.set_no_free = 1'b1;
                    state_next      = S_DONE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_FREE_EV:
            begin
                cmd.free_eval = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == S_IDLE);
        end
    end

    assign s_tready = ready_reg;

endmodule

// ----- src/block_bitmap_allocator_top.sv -----
// Top level of the block bitmap allocator.
// Input stream: s_tuser = operation (0 allocate, 1 free), s_tdata[11:0] = block
// to free. Output stream: m_tdata[11:0] = allocated block (0 unless an
// allocate succeeds), m_tdata[13:12] = status (0 ok, 1 no free block,
// 2 already free, 3 out of range or reserved).
// Config: cfg_we with cfg_index 0 = total_blocks, 1 = first_data_block,
// cfg_data 13 bits; write only while no request is in flight.
// One request at a time. An allocate reads one 32-bit bitmap word per cycle
// from the bitmap RAM, starting at the word holding first_data_block, and
// stops at the first word with a free block in the window or at the last
// word; its result is loaded into the output register and s_tready returns
// on the same edge. A free takes one RAM read of the word holding the block.
// Range faults and an empty window finish without a RAM read.
// The result sits in an output register; the next request is accepted while
// it waits. If the receiver stalls, the following request completes its
// work and holds in its final state until the output register frees.
// Reset clears the whole bitmap at once via per-word valid bits; the block
// is ready immediately after reset with total_blocks 4096 and
// first_data_block 0.
`timescale 1ns / 1ps

module block_bitmap_allocator_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [bba_pkg::REG_W-1:0]       cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bba_pkg::IN_TDATA_W-1:0]  s_tdata,   // [11:0] block_number
    input  logic                            s_tuser,   // [0] operation
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bba_pkg::OUT_TDATA_W-1:0] m_tdata    // [11:0] allocated_block, [13:12] status
);

    bba_pkg::cmd_t cmd;
    bba_pkg::sts_t sts;

    bba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bba_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready stayed high after an accepted beat");

    a_block_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[13:12] != bba_pkg::ST_OK)) |-> (m_tdata[11:0] == '0))
        else $error("nonzero block number with a failing status");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared while no request was in flight");
`endif

endmodule

// ----- tb/tb_block_bitmap_allocator_top.sv -----
// Self-checking testbench for the block bitmap allocator top level.
`timescale 1ns / 1ps

module tb_block_bitmap_allocator_top;

    localparam int  CLK_HALF_NS   = 6;
    localparam int  RESET_CYCLES  = 8;
    localparam int  SETTLE_CYCLES = 6;
    localparam int  TAIL_CYCLES   = 40;
    localparam int  RANDOM_ITEMS  = 1900;
    localparam int  HOLD_CYCLES   = 400;
    localparam int  REG_ALL_ONES  = (1 << bba_pkg::REG_W) - 1;
    localparam longint TIMEOUT_NS = 40_000_000;

    typedef struct packed {
        logic [bba_pkg::BLK_W-1:0] blk;
        bba_pkg::status_t          status;
    } alloc_result_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic                            cfg_index = bba_pkg::REG_TOTAL_BLOCKS;
    logic [bba_pkg::REG_W-1:0]       cfg_data = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [bba_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
    logic                            s_tuser = bba_pkg::OP_ALLOC;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [bba_pkg::OUT_TDATA_W-1:0] m_tdata;

    // allocator image: configuration and one in-use bit per block
    logic [bba_pkg::REG_W-1:0] cfg_total = bba_pkg::TOTAL_RESET;
    logic [bba_pkg::REG_W-1:0] cfg_first = bba_pkg::FIRST_RESET;
    bit                        block_in_use [0:bba_pkg::MAX_BLOCKS-1];

    alloc_result_t pending_results[$];
    int            mismatch_count = 0;
    int            rx_hold_cycles = 0;
    bit            burst_mode = 1'b0;
    bit            tx_held = 1'b0;

    block_bitmap_allocator_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #(CLK_HALF_NS) clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int draw_gap();
        return burst_mode ? 0 : $urandom_range(0, 10);
    endfunction

    function automatic int effective_count();
        return (cfg_total > bba_pkg::MAX_BLOCKS) ? bba_pkg::MAX_BLOCKS : int'(cfg_total);
    endfunction

    function automatic alloc_result_t predict_request(input logic op,
                                                      input logic [bba_pkg::BLK_W-1:0] blk);
        alloc_result_t res;
        int            count;
        int            n;
        count = effective_count();
        res.blk = '0;
        if (op == bba_pkg::OP_ALLOC)
        begin
            res.status = bba_pkg::ST_NO_FREE;
            for (n = int'(cfg_first); n < count; n++)
            begin
                if (!block_in_use[n])
                begin
                    block_in_use[n] = 1'b1;
                    res.blk = n[bba_pkg::BLK_W-1:0];
                    res.status = bba_pkg::ST_OK;
                    break;
                end
            end
        end
        else if (int'(blk) >= count || int'(blk) < int'(cfg_first))
            res.status = bba_pkg::ST_RANGE;
        else if (!block_in_use[blk])
            res.status = bba_pkg::ST_ALREADY_FREE;
        else
        begin
            block_in_use[blk] = 1'b0;
            res.status = bba_pkg::ST_OK;
        end
        return res;
    endfunction

    task automatic release_input();
        if (tx_held)
        begin
            s_tvalid <= 1'b0;
            tx_held = 1'b0;
        end
    endtask

    task automatic send_request(input logic op, input logic [bba_pkg::BLK_W-1:0] blk);
        int gap;
        gap = draw_gap();
        // valid already low: hold it low before raising it so it is not dropped and raised at once
        if (!tx_held && gap == 0)
            gap = 1;
        if (gap > 0)
        begin
            release_input();
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(bba_pkg::IN_TDATA_W-bba_pkg::BLK_W){1'b0}}, blk};
        tx_held = 1'b1;
        do @(posedge clk); while (s_tready !== 1'b1);
        pending_results.push_back(predict_request(op, blk));
    endtask

    task automatic wait_for_results();
        release_input();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_window(input logic [bba_pkg::REG_W-1:0] total,
                              input logic [bba_pkg::REG_W-1:0] first);
        wait_for_results();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= bba_pkg::REG_TOTAL_BLOCKS;
        cfg_data  <= total;
        @(posedge clk);
        cfg_index <= bba_pkg::REG_FIRST_DATA;
        cfg_data  <= first;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cfg_total = total;
        cfg_first = first;
    endtask

    // result beats: random stalls, plus a long hold-off when requested
    initial
    begin : result_checker
        int            stall;
        alloc_result_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = (rx_hold_cycles > 0) ? rx_hold_cycles : draw_gap();
            rx_hold_cycles = 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (m_tvalid !== 1'b1);
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat, tdata %h", $time, m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[bba_pkg::BLK_W-1:0] !== want.blk)
                begin
                    $display("%0t: allocated_block expected %0d actual %0d",
                             $time, want.blk, m_tdata[bba_pkg::BLK_W-1:0]);
                    mismatch_count++;
                end
                if (m_tdata[bba_pkg::BLK_W+bba_pkg::STATUS_W-1:bba_pkg::BLK_W] !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status,
                             m_tdata[bba_pkg::BLK_W+bba_pkg::STATUS_W-1:bba_pkg::BLK_W]);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic test_reset_window();
        send_request(bba_pkg::OP_ALLOC, 12'd0);
        send_request(bba_pkg::OP_ALLOC, 12'hFFF);
        send_request(bba_pkg::OP_FREE, 12'd1);
        send_request(bba_pkg::OP_FREE, 12'd1);
        send_request(bba_pkg::OP_FREE, 12'hFFF);
        send_request(bba_pkg::OP_FREE, 12'd0);
    endtask

    task automatic test_window_edges();
        // count above capacity, window at the top of the map
        set_window(bba_pkg::REG_W'(REG_ALL_ONES), bba_pkg::REG_W'(bba_pkg::MAX_BLOCKS - 2));
        send_request(bba_pkg::OP_ALLOC, 12'd0);
        send_request(bba_pkg::OP_ALLOC, 12'd0);
        send_request(bba_pkg::OP_ALLOC, 12'd0);
        send_request(bba_pkg::OP_FREE, 12'hFFF);
        send_request(bba_pkg::OP_FREE, bba_pkg::BLK_W'(bba_pkg::MAX_BLOCKS - 3));
        // nothing managed
        set_window(bba_pkg::REG_W'(0), bba_pkg::REG_W'(0));
        send_request(bba_pkg::OP_ALLOC, 12'd0);
        send_request(bba_pkg::OP_FREE, 12'd0);
        // reserved region covers the whole map
        set_window(bba_pkg::REG_W'(bba_pkg::MAX_BLOCKS), bba_pkg::REG_W'(bba_pkg::MAX_BLOCKS));
        send_request(bba_pkg::OP_ALLOC, 12'd0);
        send_request(bba_pkg::OP_FREE, 12'hFFF);
        set_window(bba_pkg::REG_W'(5), bba_pkg::REG_W'(REG_ALL_ONES));
        send_request(bba_pkg::OP_ALLOC, 12'd0);
        send_request(bba_pkg::OP_FREE, 12'd4);
        set_window(bba_pkg::REG_W'(bba_pkg::MAX_BLOCKS), bba_pkg::REG_W'(0));
        send_request(bba_pkg::OP_FREE, bba_pkg::BLK_W'(bba_pkg::MAX_BLOCKS - 2));
        send_request(bba_pkg::OP_ALLOC, 12'd0);
    endtask

    task automatic test_backpressure();
        int i;
        set_window(bba_pkg::REG_W'(48), bba_pkg::REG_W'(16));
        rx_hold_cycles = HOLD_CYCLES;
        burst_mode = 1'b1;
        for (i = 0; i < 14; i++)
            send_request((i % 4 == 3) ? bba_pkg::OP_FREE : bba_pkg::OP_ALLOC,
                         bba_pkg::BLK_W'(16 + i / 2));
        burst_mode = 1'b0;
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        int                        sent;
        int                        phase_len;
        int                        alloc_pct;
        int                        win_size;
        int                        win_first;
        int                        count;
        int                        pick;
        int                        i;
        logic                      op;
        logic [bba_pkg::BLK_W-1:0] blk;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 15);
            if (pick == 0)
                set_window(bba_pkg::REG_W'(bba_pkg::MAX_BLOCKS), bba_pkg::REG_W'(0));
            else if (pick == 1)
                set_window(bba_pkg::REG_W'($urandom_range(0, REG_ALL_ONES)),
                           bba_pkg::REG_W'($urandom_range(0, REG_ALL_ONES)));
            else
            begin
                win_size  = $urandom_range(1, 160);
                win_first = $urandom_range(0, bba_pkg::MAX_BLOCKS - win_size);
                set_window(bba_pkg::REG_W'(win_first + win_size), bba_pkg::REG_W'(win_first));
            end
            burst_mode = ($urandom_range(0, 3) == 0);
            alloc_pct  = $urandom_range(25, 75);
            phase_len  = $urandom_range(40, 80);
            count      = effective_count();
            for (i = 0; i < phase_len; i++)
            begin
                op   = ($urandom_range(0, 99) < alloc_pct) ? bba_pkg::OP_ALLOC
                                                           : bba_pkg::OP_FREE;
                pick = $urandom_range(0, 19);
                if (pick < 15 && count > int'(cfg_first))
                    blk = bba_pkg::BLK_W'($urandom_range(int'(cfg_first), count - 1));
                else if (pick == 15)
                    blk = bba_pkg::BLK_W'(cfg_first - 1);
                else if (pick == 16)
                    blk = bba_pkg::BLK_W'(count);
                else if (pick == 17)
                    blk = bba_pkg::BLK_W'(count - 1);
                else
                    blk = bba_pkg::BLK_W'($urandom());
                send_request(op, blk);
            end
            sent += phase_len;
        end
        burst_mode = 1'b0;
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_window();
        test_window_edges();
        test_backpressure();
        test_random_traffic();
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
src/bba_pkg.sv
src/bba_ram.sv
src/bba_datapath.sv
src/bba_ctrl.sv
src/block_bitmap_allocator_top.sv
tb/tb_block_bitmap_allocator_top.sv
